FILE: hdl/mapm_pkg.sv
// ----------------------------------------------------------------------------
// mapm_pkg
// Shared constants and types for the moisture averaging and percent map block.
// ----------------------------------------------------------------------------
package mapm_pkg;

  // Calibration registers and result fields
  localparam int unsigned CAL_W      = 10;
  localparam int unsigned PCT_W      = 7;
  localparam int unsigned CFG_ADDR_W = 1;

  localparam logic [CAL_W-1:0] DRY_CAL_RST = CAL_W'(850);
  localparam logic [CAL_W-1:0] WET_CAL_RST = CAL_W'(400);
  localparam logic [PCT_W-1:0] PCT_FULL    = PCT_W'(100);
  localparam logic [PCT_W-1:0] PCT_NONE    = PCT_W'(0);

  // Defaults for the top-level parameters
  localparam int unsigned WINDOW_DEF      = 10;
  localparam int unsigned SAMPLE_BITS_DEF = 10;

  // Register indexes on the configuration port
  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_DRY_CAL = 1'b0,
    REG_WET_CAL = 1'b1
  } mapm_reg_e;

  // Item sequencer
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MEAN_GO,
    ST_MEAN_DIV,
    ST_MAP,
    ST_PCT_DIV,
    ST_DONE
  } mapm_state_e;

endpackage

FILE: hdl/moisture_average_percent_map.sv
// ----------------------------------------------------------------------------
// moisture_average_percent_map
// Windowed mean of raw moisture samples, mapped to a calibrated percentage.
// ----------------------------------------------------------------------------
// The result comes from two passes through the shared bit-serial divider
//   (mean, percent); a mean at or beyond either calibration point skips the
//   second pass.
// Flow: one word in flight; the next is taken once the result is loaded
//   into the output register.
// Reset: ring cleared to zero, count and slot zero, dry 850, wet 400.
module moisture_average_percent_map #(
  parameter int unsigned WINDOW      = mapm_pkg::WINDOW_DEF,
  parameter int unsigned SAMPLE_BITS = mapm_pkg::SAMPLE_BITS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [mapm_pkg::CFG_ADDR_W-1:0] cfg_addr_i,
  input  logic [mapm_pkg::CAL_W-1:0]      cfg_wdata_i,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [SAMPLE_BITS-1:0]          raw_sample_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [mapm_pkg::PCT_W-1:0]      moisture_percent_o,
  output logic [mapm_pkg::CAL_W-1:0]      filtered_value_o
);

  localparam int unsigned CAL_W     = mapm_pkg::CAL_W;
  localparam int unsigned PCT_W     = mapm_pkg::PCT_W;
  localparam int unsigned CNT_W     = $clog2(WINDOW + 1);
  localparam int unsigned SLOT_W    = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int unsigned SUM_W     = SAMPLE_BITS + CNT_W;
  localparam int unsigned PNUM_W    = CAL_W + PCT_W;
  localparam int unsigned CMP_W     = (SAMPLE_BITS > CAL_W) ? SAMPLE_BITS : CAL_W;
  localparam int unsigned DIV_NUM_W = (SUM_W > PNUM_W) ? SUM_W : PNUM_W;
  localparam int unsigned DIV_DEN_W = (CNT_W > CAL_W) ? CNT_W : CAL_W;

  mapm_pkg::mapm_state_e state_q, state_d;

  logic [SAMPLE_BITS-1:0] ring_q [WINDOW];
  logic [SLOT_W-1:0]      slot_q;
  logic [CNT_W-1:0]       cnt_q;
  logic [SUM_W-1:0]       sum_q;
  logic [CAL_W-1:0]       dry_q, wet_q;
  logic [SAMPLE_BITS-1:0] mean_q, mean_d;
  logic [PCT_W-1:0]       pct_q, pct_d;
  logic                   out_valid_q;
  logic [PCT_W-1:0]       out_pct_q;
  logic [CAL_W-1:0]       out_filt_q;

  logic                   take_in;
  logic                   load_out;
  logic                   div_start;
  logic [DIV_NUM_W-1:0]   div_num;
  logic [DIV_DEN_W-1:0]   div_den;
  logic                   div_done;
  logic [DIV_NUM_W-1:0]   div_quot;
  logic [CMP_W-1:0]       mean_ext;
  logic [CAL_W-1:0]       above;
  logic [PNUM_W-1:0]      above_x100;
  logic [CAL_W-1:0]       span;

  assign in_ready_o = (state_q == mapm_pkg::ST_IDLE);
  assign take_in    = in_valid_i && in_ready_o;

  assign mean_ext = CMP_W'(mean_q);
  assign above    = dry_q - mean_ext[CAL_W-1:0];
  assign span     = dry_q - wet_q;
  // times 100 as 64 + 32 + 4
  assign above_x100 = (PNUM_W'(above) << 6) + (PNUM_W'(above) << 5) + (PNUM_W'(above) << 2);

  mapm_div #(
    .NUM_W (DIV_NUM_W),
    .DEN_W (DIV_DEN_W)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .done_o  (div_done),
    .quot_o  (div_quot)
  );

  // Sequencer
  always_comb begin
    state_d   = state_q;
    mean_d    = mean_q;
    pct_d     = pct_q;
    div_start = 1'b0;
    div_num   = DIV_NUM_W'(sum_q);
    div_den   = DIV_DEN_W'(cnt_q);
    load_out  = 1'b0;
    case (state_q)
      mapm_pkg::ST_IDLE: begin
        if (take_in) state_d = mapm_pkg::ST_MEAN_GO;
      end
      mapm_pkg::ST_MEAN_GO: begin
        div_start = 1'b1;
        state_d   = mapm_pkg::ST_MEAN_DIV;
      end
      mapm_pkg::ST_MEAN_DIV: begin
        if (div_done) begin
          mean_d  = div_quot[SAMPLE_BITS-1:0];
          state_d = mapm_pkg::ST_MAP;
        end
      end
      mapm_pkg::ST_MAP: begin
        div_num = DIV_NUM_W'(above_x100);
        div_den = DIV_DEN_W'(span);
        if (mean_ext >= CMP_W'(dry_q)) begin
          pct_d   = mapm_pkg::PCT_NONE;
          state_d = mapm_pkg::ST_DONE;
        end else if (mean_ext <= CMP_W'(wet_q)) begin
          pct_d   = mapm_pkg::PCT_FULL;
          state_d = mapm_pkg::ST_DONE;
        end else begin
          div_start = 1'b1;
          state_d   = mapm_pkg::ST_PCT_DIV;
        end
      end
      mapm_pkg::ST_PCT_DIV: begin
        if (div_done) begin
          if (div_quot > DIV_NUM_W'(mapm_pkg::PCT_FULL)) begin
            pct_d = mapm_pkg::PCT_FULL;
          end else begin
            pct_d = div_quot[PCT_W-1:0];
          end
          state_d = mapm_pkg::ST_DONE;
        end
      end
      mapm_pkg::ST_DONE: begin
        // hold until the output register is free
        if (!out_valid_q || out_ready_i) begin
          load_out = 1'b1;
          state_d  = mapm_pkg::ST_IDLE;
        end
      end
      default: state_d = mapm_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= mapm_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Ring, running sum, slot and count; the running sum relies on unfilled
  // slots reading as zero.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < WINDOW; i++) ring_q[i] <= '0;
      slot_q <= '0;
      cnt_q  <= '0;
      sum_q  <= '0;
    end else if (take_in) begin
      ring_q[slot_q] <= raw_sample_i;
      sum_q <= sum_q + SUM_W'(raw_sample_i) - SUM_W'(ring_q[slot_q]);
      if (slot_q == SLOT_W'(WINDOW - 1)) begin
        slot_q <= '0;
      end else begin
        slot_q <= slot_q + 1'b1;
      end
      if (cnt_q != CNT_W'(WINDOW)) cnt_q <= cnt_q + 1'b1;
    end
  end

  // Calibration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dry_q <= mapm_pkg::DRY_CAL_RST;
      wet_q <= mapm_pkg::WET_CAL_RST;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        mapm_pkg::REG_DRY_CAL: dry_q <= cfg_wdata_i;
        mapm_pkg::REG_WET_CAL: wet_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    mean_q <= mean_d;
    pct_q  <= pct_d;
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load_out) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      out_pct_q  <= pct_q;
      out_filt_q <= mean_ext[CAL_W-1:0];
    end
  end

  assign out_valid_o        = out_valid_q;
  assign moisture_percent_o = out_pct_q;
  assign filtered_value_o   = out_filt_q;

  // Checks
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(WINDOW))
    else $error("valid count above window");

  a_cnt_after_take: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take_in |=> cnt_q != '0)
    else $error("count zero after an accepted word");

  a_pct_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> out_pct_q <= mapm_pkg::PCT_FULL)
    else $error("percent above full scale");

  a_div_done_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (state_q == mapm_pkg::ST_MEAN_DIV || state_q == mapm_pkg::ST_PCT_DIV))
    else $error("divider finished outside a wait state");

endmodule

FILE: hdl/mapm_div.sv
// ----------------------------------------------------------------------------
// mapm_div
// Restoring bit-serial divider: one quotient bit per cycle.
// ----------------------------------------------------------------------------
module mapm_div #(
  parameter int unsigned NUM_W = 17,
  parameter int unsigned DEN_W = 10
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [NUM_W-1:0] num_i,
  input  logic [DEN_W-1:0] den_i,
  output logic             done_o,
  output logic [NUM_W-1:0] quot_o
);

  localparam int unsigned STEP_W = $clog2(NUM_W + 1);

  logic [NUM_W-1:0]  quot_q, quot_d;
  logic [DEN_W-1:0]  rem_q, rem_d;
  logic [DEN_W-1:0]  den_q, den_d;
  logic [STEP_W-1:0] step_q, step_d;
  logic              run_q, run_d;
  logic              done_q, done_d;
  logic [DEN_W:0]    trial;
  logic              fits;

  // Bring down the next dividend bit and try the subtract
  assign trial = {rem_q, quot_q[NUM_W-1]};
  assign fits  = (trial >= {1'b0, den_q});

  always_comb begin
    quot_d = quot_q;
    rem_d  = rem_q;
    den_d  = den_q;
    step_d = step_q;
    run_d  = run_q;
    done_d = 1'b0;
    if (start_i) begin
      quot_d = num_i;
      rem_d  = '0;
      den_d  = den_i;
      step_d = STEP_W'(NUM_W);
      run_d  = 1'b1;
    end else if (run_q) begin
      quot_d = {quot_q[NUM_W-2:0], fits};
      rem_d  = fits ? DEN_W'(trial - {1'b0, den_q}) : trial[DEN_W-1:0];
      step_d = step_q - 1'b1;
      if (step_q == STEP_W'(1)) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      run_q  <= run_d;
      done_q <= done_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quot_q <= quot_d;
    rem_q  <= rem_d;
    den_q  <= den_d;
  end

  assign done_o = done_q;
  assign quot_o = quot_q;

endmodule
